FILE: sv/wsd_pkg.sv
package wsd_pkg;

	// width of the payload length counter
	localparam int unsigned LEN_BITS = 64;

	// header decoding constants
	localparam logic [7:0] HDR_FIN_BIT   = 8'h80;
	localparam logic [7:0] HDR_OP_MASK   = 8'h0F;
	localparam logic [7:0] HDR_LEN_MASK  = 8'h7F;
	localparam logic [6:0] LEN7_EXT16    = 7'd126;
	localparam logic [6:0] LEN7_EXT64    = 7'd127;
	localparam logic [2:0] EXT16_COUNT   = 3'd1;
	localparam logic [2:0] EXT64_COUNT   = 3'd7;
	localparam logic [15:0] CLOSE_DEFAULT = 16'd1000;

	// opcodes
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// frame end events
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_TEXT    = 3'd1;
	localparam logic [2:0] EV_BINARY  = 3'd2;
	localparam logic [2:0] EV_CLOSE   = 3'd3;
	localparam logic [2:0] EV_PING    = 3'd4;
	localparam logic [2:0] EV_PONG    = 3'd5;
	localparam logic [2:0] EV_IGNORED = 3'd6;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_MASK = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	typedef struct packed {
		logic        has_data;
		logic [7:0]  data_byte;
		logic [3:0]  frame_opcode;
		logic        fin_flag;
		logic        frame_last;
		logic [2:0]  frame_event;
		logic [15:0] close_code;
	} result_t;

	function automatic logic [2:0] event_of(input logic [3:0] op);
		logic [2:0] ev;
		case (op)
			OP_TEXT:   ev = EV_TEXT;
			OP_BINARY: ev = EV_BINARY;
			OP_CLOSE:  ev = EV_CLOSE;
			OP_PING:   ev = EV_PING;
			OP_PONG:   ev = EV_PONG;
			default:   ev = EV_IGNORED;
		endcase
		return ev;
	endfunction

	function automatic logic is_data_op(input logic [3:0] op);
		return (op == OP_TEXT) || (op == OP_BINARY) || (op == OP_CLOSE);
	endfunction

endpackage

FILE: sv/websocket_frame_deframer.sv
// WebSocket (RFC 6455) receive deframer. One received byte per cycle goes in on
// in_valid/in_stall; each byte is held in an input register while it is parsed,
// its word goes to the output register, and the block sustains one byte per cycle
// unless stalled. Header bytes, mask keys and the payload of ping, pong,
// continuation and unknown frames give no output word; text, binary and close
// payload bytes come out unmasked with has_data set, and every frame ends with
// exactly one word flagged frame_last carrying its frame_event (a zero-length
// frame reports on its last header byte). close_code follows the first two
// close payload bytes and reads 1000 until both have arrived. in_stall rises
// only when a byte in the input register would give a word while the output
// register is full and stalled.
module websocket_frame_deframer import wsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        has_data,
	output logic [7:0]  data_byte,
	output logic [3:0]  frame_opcode,
	output logic        fin_flag,
	output logic        frame_last,
	output logic [2:0]  frame_event,
	output logic [15:0] close_code
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid;
	result_t    res;
	result_t    out_res;
	logic       out_ready;
	logic       advance;
	logic       fire;
	logic       in_take;

	// the byte in the input register moves on unless its word is blocked
	assign advance  = !res_valid || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	wsd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.ready     (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	// output fields
	assign has_data     = out_res.has_data;
	assign data_byte    = out_res.data_byte;
	assign frame_opcode = out_res.frame_opcode;
	assign fin_flag     = out_res.fin_flag;
	assign frame_last   = out_res.frame_last;
	assign frame_event  = out_res.frame_event;
	assign close_code   = out_res.close_code;

`ifndef SYNTHESIS
	// an event is only reported on the last word of a frame
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_event != EV_NONE |-> frame_last)
		else $error("frame event outside frame end");

	// a word without data is always a frame end with a clear data byte
	a_nodata_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_data |-> frame_last && data_byte == 8'h00)
		else $error("empty word not at frame end");

	// payload bytes only come from text, binary or close frames
	a_data_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_data |->
			frame_opcode == OP_TEXT || frame_opcode == OP_BINARY ||
			frame_opcode == OP_CLOSE)
		else $error("payload byte from control frame");

	// close code is zero outside close frames
	a_close_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_opcode != OP_CLOSE |-> close_code == 16'd0)
		else $error("close code on non-close frame");

	// a stalled input register only holds while the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");
`endif

endmodule

FILE: sv/wsd_parse.sv
module wsd_parse import wsd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    byte_s1,
	output logic          res_valid,
	output result_t       res
);

	phase_t               phase_q, phase_d;
	logic [3:0]           opcode_q, opcode_d;
	logic                 fin_q, fin_d;
	logic                 masked_q, masked_d;
	logic [LEN_BITS-1:0]  rem_q, rem_d;
	logic [2:0]           ext_cnt_q, ext_cnt_d;
	logic [31:0]          key_q, key_d;
	logic [1:0]           idx_q, idx_d;
	logic [1:0]           seen_q, seen_d;
	logic [15:0]          code_q, code_d;

	logic [6:0]           len7;
	logic [7:0]           key_byte;
	logic [7:0]           plain;
	logic [LEN_BITS-1:0]  rem_dec;
	logic                 hdr_end;
	logic                 data_last;

	assign len7    = byte_s1[6:0] & HDR_LEN_MASK[6:0];
	assign rem_dec = rem_q - LEN_BITS'(1);

	// key byte for the current payload position
	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign plain = masked_q ? (byte_s1 ^ key_byte) : byte_s1;

	// next state and result for the word in the input register
	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		fin_d     = fin_q;
		masked_d  = masked_q;
		rem_d     = rem_q;
		ext_cnt_d = ext_cnt_q;
		key_d     = key_q;
		idx_d     = idx_q;
		seen_d    = seen_q;
		code_d    = code_q;
		hdr_end   = 1'b0;
		data_last = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_HDR0: begin
				fin_d    = (byte_s1 & HDR_FIN_BIT) != 8'h00;
				opcode_d = byte_s1[3:0] & HDR_OP_MASK[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d = byte_s1[7];
				key_d    = '0;
				idx_d    = '0;
				seen_d   = '0;
				code_d   = CLOSE_DEFAULT;
				rem_d    = '0;
				if (len7 == LEN7_EXT16) begin
					ext_cnt_d = EXT16_COUNT;
					phase_d   = PH_EXT;
				end else if (len7 == LEN7_EXT64) begin
					ext_cnt_d = EXT64_COUNT;
					phase_d   = PH_EXT;
				end else begin
					rem_d = LEN_BITS'(len7);
					if (byte_s1[7]) begin
						phase_d = PH_MASK;
					end else begin
						hdr_end = 1'b1;
					end
				end
			end
			PH_EXT: begin
				rem_d = {rem_q[LEN_BITS-9:0], byte_s1};
				if (ext_cnt_q == 3'd0) begin
					if (masked_q) begin
						idx_d   = '0;
						phase_d = PH_MASK;
					end else begin
						hdr_end = 1'b1;
					end
				end else begin
					ext_cnt_d = ext_cnt_q - 3'd1;
				end
			end
			PH_MASK: begin
				key_d = {key_q[23:0], byte_s1};
				idx_d = idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					hdr_end = 1'b1;
				end
			end
			PH_DATA: begin
				idx_d     = idx_q + 2'd1;
				rem_d     = rem_dec;
				data_last = rem_dec == '0;
				if (data_last) begin
					phase_d = PH_HDR0;
				end
				if (opcode_q == OP_CLOSE && seen_q < 2'd2) begin
					if (seen_q == 2'd0) begin
						code_d = {plain, 8'h00};
					end else begin
						code_d = {code_q[15:8], plain};
					end
					seen_d = seen_q + 2'd1;
				end
				if (is_data_op(opcode_q)) begin
					res_valid     = 1'b1;
					res.has_data  = 1'b1;
					res.data_byte = plain;
				end else if (data_last) begin
					res_valid = 1'b1;
				end
			end
			default: begin
				phase_d = PH_HDR0;
			end
		endcase

		// header finished: zero length reports now, otherwise payload follows
		if (hdr_end) begin
			if (rem_d == '0) begin
				phase_d   = PH_HDR0;
				res_valid = 1'b1;
			end else begin
				phase_d = PH_DATA;
			end
		end

		// common result fields
		res.frame_opcode = opcode_q;
		res.fin_flag     = fin_q;
		res.frame_last   = hdr_end || data_last;
		res.frame_event  = res.frame_last ? event_of(opcode_q) : EV_NONE;
		if (opcode_q != OP_CLOSE) begin
			res.close_code = '0;
		end else if (seen_d == 2'd2) begin
			res.close_code = code_d;
		end else begin
			res.close_code = CLOSE_DEFAULT;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			opcode_q  <= '0;
			fin_q     <= 1'b0;
			masked_q  <= 1'b0;
			rem_q     <= '0;
			ext_cnt_q <= '0;
			key_q     <= '0;
			idx_q     <= '0;
			seen_q    <= '0;
			code_q    <= CLOSE_DEFAULT;
		end else if (fire) begin
			phase_q   <= phase_d;
			opcode_q  <= opcode_d;
			fin_q     <= fin_d;
			masked_q  <= masked_d;
			rem_q     <= rem_d;
			ext_cnt_q <= ext_cnt_d;
			key_q     <= key_d;
			idx_q     <= idx_d;
			seen_q    <= seen_d;
			code_q    <= code_d;
		end
	end

endmodule

FILE: sv/wsd_out_reg.sv
module wsd_out_reg import wsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    out_stall,
	output logic    ready,
	output logic    out_valid,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	// register can take a new word when empty or being drained
	assign ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
